FILE: sv/drlm_pkg.sv
// ----------------------------------------------------------------------------
// drlm_pkg: shared types and constants
// Rectangle type, request codes, sequencer states and the merge helpers.
// ----------------------------------------------------------------------------
package drlm_pkg;

  localparam int unsigned EdgeW = 16;

  typedef struct packed {
    logic signed [EdgeW-1:0] top;
    logic signed [EdgeW-1:0] left;
    logic signed [EdgeW-1:0] bottom;
    logic signed [EdgeW-1:0] right;
  } rect_t;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_TOP    = 2'd0,
    CFG_LEFT   = 2'd1,
    CFG_BOTTOM = 2'd2,
    CFG_RIGHT  = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_PASS_RD,
    ST_PASS_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_HOLD_WR,
    ST_FULL_RD,
    ST_FULL_CHK,
    ST_FULL_WR,
    ST_READ_RD,
    ST_READ_WAIT,
    ST_DONE
  } state_e;

  // operation of the shared rectangle unit
  typedef enum logic [1:0] {
    OP_MEET,
    OP_JOIN
  } op_e;

  typedef struct packed {
    rect_t result;
    logic  res_empty;
    logic  mergeable;
  } alu_res_t;

  function automatic logic rect_empty(rect_t r);
    rect_empty = (r.left >= r.right) || (r.top >= r.bottom);
  endfunction

endpackage

FILE: sv/drlm_ram.sv
// ----------------------------------------------------------------------------
// drlm_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module drlm_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8
) (
  input  logic                                           clk_i,
  input  logic                                           we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]   addr_i,
  input  logic [Width-1:0]                               wdata_i,
  output logic [Width-1:0]                               rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: sv/drlm_alu.sv
// ----------------------------------------------------------------------------
// drlm_alu: shared rectangle unit
// Intersection or bounding union of two rectangles plus the merge test.
// ----------------------------------------------------------------------------
module drlm_alu (
  input  drlm_pkg::op_e    op_i,
  input  drlm_pkg::rect_t  a_i,
  input  drlm_pkg::rect_t  b_i,
  output drlm_pkg::alu_res_t res_o
);

  drlm_pkg::rect_t m;
  drlm_pkg::rect_t u;
  logic hov, vov, htouch, vtouch;

  always_comb begin
    m.top    = (a_i.top    > b_i.top)    ? a_i.top    : b_i.top;
    m.left   = (a_i.left   > b_i.left)   ? a_i.left   : b_i.left;
    m.bottom = (a_i.bottom < b_i.bottom) ? a_i.bottom : b_i.bottom;
    m.right  = (a_i.right  < b_i.right)  ? a_i.right  : b_i.right;

    u.top    = (a_i.top    < b_i.top)    ? a_i.top    : b_i.top;
    u.left   = (a_i.left   < b_i.left)   ? a_i.left   : b_i.left;
    u.bottom = (a_i.bottom > b_i.bottom) ? a_i.bottom : b_i.bottom;
    u.right  = (a_i.right  > b_i.right)  ? a_i.right  : b_i.right;

    hov    = (a_i.left < b_i.right) && (b_i.left < a_i.right);
    vov    = (a_i.top < b_i.bottom) && (b_i.top < a_i.bottom);
    htouch = (a_i.right == b_i.left) || (b_i.right == a_i.left);
    vtouch = (a_i.bottom == b_i.top) || (b_i.bottom == a_i.top);

    res_o.mergeable = !drlm_pkg::rect_empty(m) || (vov && htouch) || (hov && vtouch);

    case (op_i)
      drlm_pkg::OP_MEET: res_o.result = m;
      drlm_pkg::OP_JOIN: begin
        // union with an empty side keeps the other
        if (drlm_pkg::rect_empty(a_i)) begin
          res_o.result = b_i;
        end else if (drlm_pkg::rect_empty(b_i)) begin
          res_o.result = a_i;
        end else begin
          res_o.result = u;
        end
      end
      default: res_o.result = m;
    endcase
    res_o.res_empty = drlm_pkg::rect_empty(res_o.result);
  end

endmodule

FILE: sv/dirty_rect_list_merge_unit.sv
// ----------------------------------------------------------------------------
// dirty_rect_list_merge_unit: dirty rectangle list with merging
// Sequencer around one shared rectangle unit and a single-port entry RAM.
// ----------------------------------------------------------------------------
// One transaction at a time. A clear or a rejected add goes straight to the
// result; a read fetches the entry unless the index is past the count. An add
// is sequenced over the entry RAM, one access per cycle: the search tests
// each entry in turn, the absorb pass tests the remaining entries and moves
// the entries above each removed one down by one, and a full-list collapse
// joins every entry into one and writes it back. The single RAM port and
// the one shared merge/union unit set the pace of an add. The result is held
// in an output register until taken; the next transaction is accepted from
// the cycle after that, and in_stall_o is high while busy or while a result
// is held.
module dirty_rect_list_merge_unit #(
  parameter int unsigned CAPACITY = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic signed [15:0] rect_top_i,
  input  logic signed [15:0] rect_left_i,
  input  logic signed [15:0] rect_bottom_i,
  input  logic signed [15:0] rect_right_i,
  input  logic [2:0]  read_index_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic [3:0]  entry_count_o,
  output logic        entry_found_o,
  output logic signed [15:0] out_top_o,
  output logic signed [15:0] out_left_o,
  output logic signed [15:0] out_bottom_o,
  output logic signed [15:0] out_right_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned RW = $bits(drlm_pkg::rect_t);

  drlm_pkg::state_e state_q, state_d;
  drlm_pkg::rect_t  bounds_q;
  drlm_pkg::rect_t  acc_q, acc_d;       // clipped input, then absorbing union
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    i_q, i_d;           // absorbing entry
  logic [CW-1:0]    j_q, j_d;           // pass position
  logic [CW-1:0]    k_q, k_d;           // shift position
  logic [2:0]       ridx_q, ridx_d;

  logic                 res_acc_q, res_acc_d;
  logic                 res_found_q, res_found_d;
  drlm_pkg::rect_t      res_rect_q, res_rect_d;
  logic                 out_valid_q, out_valid_d;

  // ram port
  logic             ram_we;
  logic [CW-1:0]    ram_addr_full;
  drlm_pkg::rect_t  ram_wdata;
  logic [RW-1:0]    ram_rdata;
  drlm_pkg::rect_t  rd_rect;

  // shared unit
  drlm_pkg::op_e      op;
  drlm_pkg::rect_t    alu_a, alu_b;
  drlm_pkg::alu_res_t alu;

  drlm_pkg::rect_t in_rect;

  assign rd_rect = drlm_pkg::rect_t'(ram_rdata);
  assign in_rect = '{top: rect_top_i, left: rect_left_i,
                     bottom: rect_bottom_i, right: rect_right_i};

  drlm_ram #(.Width(RW), .Depth(CAPACITY)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr_full[AW-1:0]),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  drlm_alu u_alu (
    .op_i (op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .res_o(alu)
  );

  assign cfg_ready_o = (state_q == drlm_pkg::ST_IDLE) && !out_valid_q;
  assign in_stall_o  = (state_q != drlm_pkg::ST_IDLE) || out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (drlm_pkg::cfg_e'(cfg_index_i))
        drlm_pkg::CFG_TOP:    bounds_q.top    <= cfg_data_i;
        drlm_pkg::CFG_LEFT:   bounds_q.left   <= cfg_data_i;
        drlm_pkg::CFG_BOTTOM: bounds_q.bottom <= cfg_data_i;
        drlm_pkg::CFG_RIGHT:  bounds_q.right  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drlm_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    i_q         <= i_d;
    j_q         <= j_d;
    k_q         <= k_d;
    ridx_q      <= ridx_d;
    res_acc_q   <= res_acc_d;
    res_found_q <= res_found_d;
    res_rect_q  <= res_rect_d;
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    acc_d         = acc_q;
    i_d           = i_q;
    j_d           = j_q;
    k_d           = k_q;
    ridx_d        = ridx_q;
    res_acc_d     = res_acc_q;
    res_found_d   = res_found_q;
    res_rect_d    = res_rect_q;
    out_valid_d   = out_valid_q;
    ram_we        = 1'b0;
    ram_addr_full = '0;
    ram_wdata     = acc_q;
    op            = drlm_pkg::OP_MEET;
    alu_a         = acc_q;
    alu_b         = rd_rect;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      drlm_pkg::ST_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          res_acc_d   = 1'b0;
          res_found_d = 1'b0;
          res_rect_d  = '0;
          case (drlm_pkg::req_e'(req_type_i))
            drlm_pkg::REQ_ADD: begin
              op    = drlm_pkg::OP_MEET;
              alu_a = in_rect;
              alu_b = bounds_q;
              acc_d = alu.result;
              i_d   = '0;
              if (alu.res_empty) begin
                state_d = drlm_pkg::ST_DONE;
              end else begin
                res_acc_d = 1'b1;
                state_d   = drlm_pkg::ST_SCAN_RD;
              end
            end
            drlm_pkg::REQ_CLEAR: begin
              cnt_d     = '0;
              res_acc_d = 1'b1;
              state_d   = drlm_pkg::ST_DONE;
            end
            drlm_pkg::REQ_READ: begin
              ridx_d  = read_index_i;
              state_d = drlm_pkg::ST_READ_RD;
            end
            default: state_d = drlm_pkg::ST_DONE;
          endcase
        end
      end

      drlm_pkg::ST_READ_RD: begin
        ram_addr_full = CW'(ridx_q);
        if (int'(ridx_q) < int'(cnt_q)) begin
          state_d = drlm_pkg::ST_READ_WAIT;
        end else begin
          state_d = drlm_pkg::ST_DONE;
        end
      end

      drlm_pkg::ST_READ_WAIT: begin
        res_found_d = 1'b1;
        res_rect_d  = rd_rect;
        state_d     = drlm_pkg::ST_DONE;
      end

      // search for the first mergeable entry
      drlm_pkg::ST_SCAN_RD: begin
        ram_addr_full = i_q;
        if (i_q < cnt_q) begin
          state_d = drlm_pkg::ST_SCAN_CHK;
        end else if (cnt_q < CW'(CAPACITY)) begin
          ram_we  = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = drlm_pkg::ST_DONE;
        end else begin
          j_d     = '0;
          state_d = drlm_pkg::ST_FULL_RD;
        end
      end

      drlm_pkg::ST_SCAN_CHK: begin
        if (alu.mergeable) begin
          op      = drlm_pkg::OP_JOIN;
          acc_d   = alu.result;
          j_d     = '0;
          state_d = drlm_pkg::ST_PASS_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = drlm_pkg::ST_SCAN_RD;
        end
      end

      // absorb pass; the union lives in acc_q and is written back at the end
      drlm_pkg::ST_PASS_RD: begin
        ram_addr_full = j_q;
        if (j_q >= cnt_q) begin
          state_d = drlm_pkg::ST_HOLD_WR;
        end else if (j_q == i_q) begin
          j_d = j_q + 1'b1;
        end else begin
          state_d = drlm_pkg::ST_PASS_CHK;
        end
      end

      drlm_pkg::ST_PASS_CHK: begin
        if (alu.mergeable) begin
          op    = drlm_pkg::OP_JOIN;
          acc_d = alu.result;
          if (j_q < i_q) begin
            i_d = i_q - 1'b1;
          end
          k_d     = j_q;
          state_d = drlm_pkg::ST_SHIFT_RD;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = drlm_pkg::ST_PASS_RD;
        end
      end

      // move entries above k down by one
      drlm_pkg::ST_SHIFT_RD: begin
        ram_addr_full = k_q + 1'b1;
        if (k_q + 1'b1 < cnt_q) begin
          state_d = drlm_pkg::ST_SHIFT_WR;
        end else begin
          cnt_d   = cnt_q - 1'b1;
          state_d = drlm_pkg::ST_PASS_RD;
        end
      end

      drlm_pkg::ST_SHIFT_WR: begin
        ram_we        = 1'b1;
        ram_addr_full = k_q;
        ram_wdata     = rd_rect;
        k_d           = k_q + 1'b1;
        state_d       = drlm_pkg::ST_SHIFT_RD;
      end

      drlm_pkg::ST_HOLD_WR: begin
        ram_we        = 1'b1;
        ram_addr_full = i_q;
        state_d       = drlm_pkg::ST_DONE;
      end

      // list full: collapse everything into one entry
      drlm_pkg::ST_FULL_RD: begin
        ram_addr_full = j_q;
        if (j_q < cnt_q) begin
          state_d = drlm_pkg::ST_FULL_CHK;
        end else begin
          state_d = drlm_pkg::ST_FULL_WR;
        end
      end

      drlm_pkg::ST_FULL_CHK: begin
        op      = drlm_pkg::OP_JOIN;
        acc_d   = alu.result;
        j_d     = j_q + 1'b1;
        state_d = drlm_pkg::ST_FULL_RD;
      end

      drlm_pkg::ST_FULL_WR: begin
        ram_we        = 1'b1;
        ram_addr_full = '0;
        cnt_d         = CW'(1);
        state_d       = drlm_pkg::ST_DONE;
      end

      drlm_pkg::ST_DONE: begin
        out_valid_d = 1'b1;
        state_d     = drlm_pkg::ST_IDLE;
      end

      default: state_d = drlm_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = res_acc_q;
  assign entry_count_o = 4'(cnt_q);
  assign entry_found_o = res_found_q;
  assign out_top_o     = res_rect_q.top;
  assign out_left_o    = res_rect_q.left;
  assign out_bottom_o  = res_rect_q.bottom;
  assign out_right_o   = res_rect_q.right;

endmodule
